>>> rtl/scp_pkg.sv
// Package with types, constants and header bytes shared by the scope capture framer.
`default_nettype none
package scp_pkg;

	localparam int DEF_NUM_CHANNELS = 4;
	localparam int DEF_BANK_DEPTH   = 64;
	localparam int MAX_CHANNELS     = 4;
	localparam int SAMPLE_W         = 32;
	localparam int POS_W            = 5;
	localparam int HDR_LEN          = 6;
	localparam int APB_ADDR_W       = 4;
	localparam int APB_DATA_W       = 32;

	localparam logic [POS_W-1:0] POS_SYNC   = 5'd0;
	localparam logic [POS_W-1:0] POS_TAG_S  = 5'd1;
	localparam logic [POS_W-1:0] POS_TAG_C  = 5'd2;
	localparam logic [POS_W-1:0] POS_VER    = 5'd3;
	localparam logic [POS_W-1:0] POS_NCH_LO = 5'd4;
	localparam logic [POS_W-1:0] POS_NCH_HI = 5'd5;

	localparam logic [7:0] BYTE_SYNC  = 8'hFF;
	localparam logic [7:0] BYTE_TAG_S = 8'h53;
	localparam logic [7:0] BYTE_TAG_C = 8'h43;
	localparam logic [7:0] BYTE_VER   = 8'h01;

	localparam logic KIND_CAPTURE = 1'b0;
	localparam logic KIND_SLOT    = 1'b1;

	typedef enum logic [1:0] {
		REG_CAPTURE_EN,
		REG_STREAM_EN,
		REG_CHANNEL_MASK
	} reg_idx_t;

	typedef struct packed {
		logic                       kind;
		logic signed [SAMPLE_W-1:0] sample_ch0;
		logic signed [SAMPLE_W-1:0] sample_ch1;
		logic signed [SAMPLE_W-1:0] sample_ch2;
		logic signed [SAMPLE_W-1:0] sample_ch3;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_last;
	} rsp_t;

	typedef struct packed {
		logic             valid;
		logic             last;
		logic [POS_W-1:0] pos;
	} s1_ctl_t;

endpackage
`default_nettype wire

>>> rtl/scp_sample_mem.sv
// Ping-pong sample store: one row per sample set, one write and one registered read port.
`default_nettype none
module scp_sample_mem #(
	parameter int ROW_W  = 128,
	parameter int DEPTH  = 128,
	parameter int ADDR_W = 7
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [ROW_W-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [ROW_W-1:0]  rdata
);

	logic [ROW_W-1:0] mem [0:DEPTH-1];
	logic [ROW_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

>>> rtl/scp_seq.sv
// Capture and frame sequencer: bank swap, indexes, byte position and memory access.
`default_nettype none
module scp_seq #(
	parameter int NUM_CHANNELS = scp_pkg::DEF_NUM_CHANNELS,
	parameter int BANK_DEPTH   = scp_pkg::DEF_BANK_DEPTH,
	parameter int ROW_W        = NUM_CHANNELS * scp_pkg::SAMPLE_W,
	parameter int ADDR_W       = $clog2(2 * BANK_DEPTH)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    accept,
	input  wire scp_pkg::req_t           req,
	input  wire logic                    capture_en,
	input  wire logic                    stream_en,
	input  wire logic [3:0]              channel_mask,
	input  wire logic                    s1_hold,
	output logic                         we,
	output logic      [ADDR_W-1:0]       waddr,
	output logic      [ROW_W-1:0]        wdata,
	output logic                         re,
	output logic      [ADDR_W-1:0]       raddr,
	output scp_pkg::s1_ctl_t             ctl_s1
);
	import scp_pkg::*;

	localparam int IDX_W     = $clog2(BANK_DEPTH);
	localparam int FRAME_LEN = HDR_LEN + 4 * NUM_CHANNELS;
	localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(BANK_DEPTH - 1);
	localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(FRAME_LEN - 1);
	localparam logic [ADDR_W-1:0] BANK_BASE = ADDR_W'(BANK_DEPTH);

	logic             bank_q;
	logic [IDX_W-1:0] widx_q;
	logic [IDX_W-1:0] ridx_q;
	logic             active_q;
	logic [POS_W-1:0] pos_q;
	s1_ctl_t          ctl_q;

	logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] smp;
	logic is_cap;
	logic is_slot;
	logic emit;
	logic drop;
	logic frame_end;
	logic advance;

	assign smp = {req.sample_ch3, req.sample_ch2, req.sample_ch1, req.sample_ch0};

	always_comb begin
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			wdata[c*SAMPLE_W +: SAMPLE_W] = channel_mask[c] ? smp[c] : '0;
		end
	end

	assign is_cap    = accept && (req.kind == KIND_CAPTURE) && capture_en;
	assign is_slot   = accept && (req.kind == KIND_SLOT) && active_q;
	assign emit      = is_slot && stream_en;
	assign drop      = is_slot && !stream_en;
	assign frame_end = pos_q == POS_LAST;
	assign advance   = drop || (emit && frame_end);

	assign we    = is_cap;
	assign waddr = {1'b0, widx_q} + (bank_q ? '0 : BANK_BASE);
	assign re    = emit;
	assign raddr = {1'b0, ridx_q} + (bank_q ? BANK_BASE : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q   <= 1'b0;
			widx_q   <= '0;
			ridx_q   <= '0;
			active_q <= 1'b0;
			pos_q    <= '0;
		end else if (is_cap) begin
			if (widx_q == IDX_LAST) begin
				widx_q   <= '0;
				ridx_q   <= '0;
				pos_q    <= '0;
				bank_q   <= !bank_q;
				active_q <= 1'b1;
			end else begin
				widx_q <= widx_q + 1'b1;
			end
		end else if (advance) begin
			pos_q  <= '0;
			ridx_q <= ridx_q + 1'b1;
			if (ridx_q == IDX_LAST) begin
				active_q <= 1'b0;
			end
		end else if (emit) begin
			pos_q <= pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (emit) begin
			ctl_q.valid <= 1'b1;
			ctl_q.pos   <= pos_q;
			ctl_q.last  <= frame_end;
		end else if (!s1_hold) begin
			ctl_q.valid <= 1'b0;
		end
	end

	assign ctl_s1 = ctl_q;

endmodule
`default_nettype wire

>>> rtl/scp_out.sv
// Frame byte selection and output register toward the link.
`default_nettype none
module scp_out #(
	parameter int NUM_CHANNELS = scp_pkg::DEF_NUM_CHANNELS,
	parameter int ROW_W        = NUM_CHANNELS * scp_pkg::SAMPLE_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire scp_pkg::s1_ctl_t ctl_s1,
	input  wire logic [ROW_W-1:0] rdata,
	input  wire logic             rsp_stall,
	output logic                  s1_hold,
	output logic                  rsp_valid,
	output scp_pkg::rsp_t         rsp
);
	import scp_pkg::*;

	localparam int ROW_BYTES = 4 * NUM_CHANNELS;
	localparam int BSEL_W    = $clog2(ROW_BYTES);

	logic [ROW_BYTES-1:0][7:0] row_bytes;
	logic [POS_W-1:0]          off;
	logic [7:0]                byte_sel;
	logic                      out_valid_q;
	rsp_t                      out_q;
	logic                      out_hold;

	assign row_bytes = rdata;
	assign off       = ctl_s1.pos - POS_W'(HDR_LEN);

	always_comb begin
		case (ctl_s1.pos)
			POS_SYNC:   byte_sel = BYTE_SYNC;
			POS_TAG_S:  byte_sel = BYTE_TAG_S;
			POS_TAG_C:  byte_sel = BYTE_TAG_C;
			POS_VER:    byte_sel = BYTE_VER;
			POS_NCH_LO: byte_sel = 8'(NUM_CHANNELS);
			POS_NCH_HI: byte_sel = 8'(NUM_CHANNELS >> 8);
			default:    byte_sel = row_bytes[off[BSEL_W-1:0]];
		endcase
	end

	assign out_hold = out_valid_q && rsp_stall;
	assign s1_hold  = ctl_s1.valid && out_hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_hold) begin
			out_valid_q <= ctl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_hold && ctl_s1.valid) begin
			out_q.out_byte   <= byte_sel;
			out_q.frame_last <= ctl_s1.last;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
`default_nettype wire

>>> rtl/scope_capture_ping_pong_framer_unit.sv
// Top level of the scope capture framer: register port, sequencer, sample store, output.
// One item per cycle unless stalled; a capture writes a row, a streamed slot reads one.
// A slot item's byte passes through the registered read of the sample store and then the
// output register on its way to the output.
// Reset clears all control state at once; the sample store and the output data registers
// are not cleared and need no clearing pass, so items are accepted right after reset.
`default_nettype none
module scope_capture_ping_pong_framer_unit #(
	parameter int NUM_CHANNELS = scp_pkg::DEF_NUM_CHANNELS,
	parameter int BANK_DEPTH   = scp_pkg::DEF_BANK_DEPTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [scp_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [scp_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [scp_pkg::APB_DATA_W-1:0] prdata,
	output logic                                pready,
	input  wire logic                           req_valid,
	output logic                                req_stall,
	input  wire scp_pkg::req_t                  req,
	output logic                                rsp_valid,
	input  wire logic                           rsp_stall,
	output scp_pkg::rsp_t                       rsp
);
	import scp_pkg::*;

	localparam int ROW_W     = NUM_CHANNELS * SAMPLE_W;
	localparam int MEM_DEPTH = 2 * BANK_DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	logic       capture_en_q;
	logic       stream_en_q;
	logic [3:0] channel_mask_q;
	reg_idx_t   reg_idx;
	logic       cfg_wr;

	logic              accept;
	logic              s1_hold;
	logic              we;
	logic              re;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic [ROW_W-1:0]  wdata;
	logic [ROW_W-1:0]  rdata;
	s1_ctl_t           ctl_s1;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_en_q   <= 1'b0;
			stream_en_q    <= 1'b0;
			channel_mask_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_CAPTURE_EN:   capture_en_q   <= pwdata[0];
				REG_STREAM_EN:    stream_en_q    <= pwdata[0];
				REG_CHANNEL_MASK: channel_mask_q <= pwdata[3:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_CAPTURE_EN:   prdata = {{(APB_DATA_W-1){1'b0}}, capture_en_q};
			REG_STREAM_EN:    prdata = {{(APB_DATA_W-1){1'b0}}, stream_en_q};
			REG_CHANNEL_MASK: prdata = {{(APB_DATA_W-4){1'b0}}, channel_mask_q};
			default:          prdata = '0;
		endcase
	end

	assign req_stall = s1_hold;
	assign accept    = req_valid && !req_stall;

	scp_seq #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.BANK_DEPTH   (BANK_DEPTH),
		.ROW_W        (ROW_W),
		.ADDR_W       (ADDR_W)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.req          (req),
		.capture_en   (capture_en_q),
		.stream_en    (stream_en_q),
		.channel_mask (channel_mask_q),
		.s1_hold      (s1_hold),
		.we           (we),
		.waddr        (waddr),
		.wdata        (wdata),
		.re           (re),
		.raddr        (raddr),
		.ctl_s1       (ctl_s1)
	);

	scp_sample_mem #(
		.ROW_W  (ROW_W),
		.DEPTH  (MEM_DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	scp_out #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.ROW_W        (ROW_W)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.rdata     (rdata),
		.rsp_stall (rsp_stall),
		.s1_hold   (s1_hold),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

>>> tb/scp_frame_checker.sv
// Checker that mirrors the scope framer's capture and readout state and checks every output byte.
module scp_frame_checker
	import scp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic                  req_valid,
	input  logic                  req_stall,
	input  req_t                  req,
	input  logic                  rsp_valid,
	input  logic                  rsp_stall,
	input  rsp_t                  rsp,
	output int                    outstanding,
	output int                    fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCH       = DEF_NUM_CHANNELS;
	localparam int DEPTH     = DEF_BANK_DEPTH;
	localparam int FRAME_LEN = HDR_LEN + 4 * NCH;

	logic [SAMPLE_W-1:0] bank_mem [0:1][0:DEPTH-1][0:NCH-1];
	logic                read_bank;
	int unsigned         wr_entry;
	int unsigned         rd_entry;
	bit                  reading;
	logic [POS_W-1:0]    frame_pos;
	bit                  cap_on;
	bit                  stream_on;
	logic [3:0]          mask;
	rsp_t                byte_q [$];
	int                  errors;

	assign fail_count = errors;

	task automatic flag_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $time, what);
		errors++;
	endtask

	function automatic logic [7:0] frame_byte(input logic [POS_W-1:0] pos);
		int unsigned         ofs;
		logic [SAMPLE_W-1:0] word;
		case (pos)
			POS_SYNC:   return BYTE_SYNC;
			POS_TAG_S:  return BYTE_TAG_S;
			POS_TAG_C:  return BYTE_TAG_C;
			POS_VER:    return BYTE_VER;
			POS_NCH_LO: return 8'(NCH);
			POS_NCH_HI: return 8'(NCH >> 8);
			default: begin
				ofs  = int'(pos) - HDR_LEN;
				word = bank_mem[read_bank][rd_entry][ofs / 4];
				return word[8 * (ofs % 4) +: 8];
			end
		endcase
	endfunction

	function automatic void next_entry();
		frame_pos = '0;
		rd_entry++;
		if (rd_entry >= DEPTH)
			reading = 1'b0;
	endfunction

	function automatic void take_item(input req_t it);
		logic [SAMPLE_W-1:0] s [0:NCH-1];
		rsp_t                r;
		if (it.kind == KIND_CAPTURE) begin
			if (!cap_on)
				return;
			s[0] = it.sample_ch0;
			s[1] = it.sample_ch1;
			s[2] = it.sample_ch2;
			s[3] = it.sample_ch3;
			for (int c = 0; c < NCH; c++)
				bank_mem[~read_bank][wr_entry][c] = mask[c] ? s[c] : '0;
			wr_entry++;
			if (wr_entry >= DEPTH) begin
				wr_entry  = 0;
				rd_entry  = 0;
				frame_pos = '0;
				read_bank = ~read_bank;
				reading   = 1'b1;
			end
			return;
		end
		if (!reading)
			return;
		if (!stream_on) begin
			next_entry();
			return;
		end
		r.out_byte   = frame_byte(frame_pos);
		r.frame_last = (int'(frame_pos) == FRAME_LEN - 1);
		if (r.frame_last)
			next_entry();
		else
			frame_pos++;
		byte_q.push_back(r);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			read_bank   = 1'b0;
			wr_entry    = 0;
			rd_entry    = 0;
			reading     = 1'b0;
			frame_pos   = '0;
			cap_on      = 1'b0;
			stream_on   = 1'b0;
			mask        = '0;
			byte_q      = {};
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_CAPTURE_EN:   cap_on = pwdata[0];
					REG_STREAM_EN:    stream_on = pwdata[0];
					REG_CHANNEL_MASK: mask = pwdata[3:0];
					default: ;
				endcase
			end
			if (rsp_valid && !rsp_stall) begin
				if (byte_q.size() == 0) begin
					flag_mismatch($sformatf("byte %02h with nothing expected", rsp.out_byte));
				end else begin
					want = byte_q.pop_front();
					if (rsp.out_byte !== want.out_byte)
						flag_mismatch($sformatf("out_byte %02h, expected %02h",
							rsp.out_byte, want.out_byte));
					if (rsp.frame_last !== want.frame_last)
						flag_mismatch($sformatf("frame_last %b, expected %b",
							rsp.frame_last, want.frame_last));
				end
			end
			if (req_valid && !req_stall)
				take_item(req);
			outstanding <= byte_q.size();
		end
	end

endmodule

>>> tb/tb_top.sv
// Top of the scope framer testbench: clock, reset, register writes, item and stall stimulus.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import scp_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 4;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  req_valid;
	logic                  req_stall;
	req_t                  req;
	logic                  rsp_valid;
	logic                  rsp_stall;
	rsp_t                  rsp;
	int                    outstanding;
	int                    fail_count;
	bit                    calm;
	bit                    hold_rsp;

	scope_capture_ping_pong_framer_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	scp_frame_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#10ms;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic req_t rand_item(input int slot_pct);
		req_t it;
		it.kind       = ($urandom_range(0, 99) < slot_pct) ? KIND_SLOT : KIND_CAPTURE;
		it.sample_ch0 = rand_sample();
		it.sample_ch1 = rand_sample();
		it.sample_ch2 = rand_sample();
		it.sample_ch3 = rand_sample();
		return it;
	endfunction

	function automatic logic [APB_ADDR_W-1:0] reg_addr(input logic [1:0] idx);
		return APB_ADDR_W'({idx, 2'b00});
	endfunction

	task automatic send(input req_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= it;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic run_mix(input int n, input int slot_pct);
		repeat (n) send(rand_item(slot_pct));
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input bit cap, input bit strm, input logic [3:0] m);
		reg_write(reg_addr(REG_CAPTURE_EN), {31'($urandom), cap});
		reg_write(reg_addr(REG_STREAM_EN), {31'($urandom), strm});
		reg_write(reg_addr(REG_CHANNEL_MASK), {28'($urandom), m});
	endtask

	initial begin : rsp_side
		int run;
		rsp_stall = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_rsp) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp = 1'b0;
			end else begin
				run = pick_gap();
				rsp_stall <= (run != 0);
				repeat (run != 0 ? run : $urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [31:0] pat [0:7];
		req_t        it;
		pat = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0000, 32'hFFFF_0000};
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		req_valid = 1'b0;
		req       = '0;
		calm      = 1'b0;
		hold_rsp  = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Captures and a slot while everything is still disabled after reset.
		run_mix(2, 0);
		run_mix(1, 100);
		settle();
		configure(1'b1, 1'b1, 4'hF);
		reg_write(reg_addr(REG_CHANNEL_MASK) + APB_ADDR_W'(4), 32'hFFFF_FFFF);
		run_mix(1, 100);
		for (int i = 0; i < 8; i++) begin
			it.kind       = KIND_CAPTURE;
			it.sample_ch0 = pat[i];
			it.sample_ch1 = pat[(i + 1) % 8];
			it.sample_ch2 = pat[(i + 2) % 8];
			it.sample_ch3 = pat[(i + 3) % 8];
			send(it);
		end

		// Fill the rest of the bank, which swaps banks, then stream frames with captures mixed in.
		run_mix(56, 0);
		run_mix(50, 100);
		run_mix(50, 60);

		// Receiver holds off while slots keep coming.
		hold_rsp = 1'b1;
		run_mix(40, 100);
		settle();

		configure(1'b1, 1'b0, 4'h5);
		run_mix(100, 50);
		settle();

		configure(1'b0, 1'b1, 4'hA);
		run_mix(80, 50);
		settle();

		configure(1'b1, 1'b1, 4'h0);
		calm = 1'b1;
		run_mix(64, 0);
		run_mix(80, 100);
		calm = 1'b0;
		run_mix(70, 70);
		settle();

		configure(1'b1, 1'b1, 4'hF);
		run_mix(100, 50);
		settle();

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/scp_pkg.sv
rtl/scp_sample_mem.sv
rtl/scp_seq.sv
rtl/scp_out.sv
rtl/scope_capture_ping_pong_framer_unit.sv
tb/scp_frame_checker.sv
tb/tb_top.sv
